>>> hw/rtl/shadow_memory_access_checker_macros.svh
// assertion macros for the shadow memory access checker
// used by the checker module; no other dependencies
`ifndef SHADOW_MEMORY_ACCESS_CHECKER_MACROS_SVH
`define SHADOW_MEMORY_ACCESS_CHECKER_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define SMAC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// next-cycle implication, disabled while reset is high
`define SMAC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

>>> hw/rtl/smac_pkg.sv
// shared constants, operation codes and types for the shadow memory access checker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package smac_pkg;

   localparam int OP_W         = 3;
   localparam int ADDR_W       = 15;
   localparam int SIZE_W       = 16;
   localparam int VAL_W        = 8;
   localparam int GRAIN_SHIFT  = 3;
   localparam int OFFSET_W     = GRAIN_SHIFT;
   localparam int END_W        = SIZE_W + 1;
   localparam int GRAIN_BYTES  = 1 << GRAIN_SHIFT;
   localparam int GRAIN_COUNT_DEF = 4096;

   localparam logic [OP_W-1:0] OP_CHECK_READ  = 3'd0;
   localparam logic [OP_W-1:0] OP_CHECK_WRITE = 3'd1;
   localparam logic [OP_W-1:0] OP_POISON      = 3'd2;
   localparam logic [OP_W-1:0] OP_UNPOISON    = 3'd3;
   localparam logic [OP_W-1:0] OP_QUERY       = 3'd4;

   // strobes from the sequencer to the shadow store
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_cmd_type;

endpackage

`default_nettype wire

>>> hw/rtl/smac_if.sv
// valid/ready channel interfaces: request, response and control register write
// depends on smac_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface smac_req_if;
   import smac_pkg::*;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [ADDR_W-1:0]   address;
   logic [SIZE_W-1:0]   size;
   logic [VAL_W-1:0]    poison_value;
   modport source (output valid, output operation, output address, output size,
                   output poison_value, input ready);
   modport sink (input valid, input operation, input address, input size,
                 input poison_value, output ready);
endinterface

interface smac_rsp_if;
   import smac_pkg::*;
   logic                valid;
   logic                ready;
   logic                error_flag;
   logic                error_is_write;
   logic [VAL_W-1:0]    shadow_value;
   logic                is_poisoned;
   logic                range_fault;
   modport source (output valid, output error_flag, output error_is_write,
                   output shadow_value, output is_poisoned, output range_fault,
                   input ready);
   modport sink (input valid, input error_flag, input error_is_write,
                 input shadow_value, input is_poisoned, input range_fault,
                 output ready);
endinterface

interface smac_csr_if;
   logic valid;
   logic ready;
   logic checking_enabled;
   modport source (output valid, output checking_enabled, input ready);
   modport sink (input valid, input checking_enabled, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/smac_store.sv
// shadow byte store, one byte per grain, with a zeroing sweep after reset
// depends on smac_pkg
`timescale 1ns / 1ps
`default_nettype none

module smac_store #(
   parameter int GRAIN_COUNT = smac_pkg::GRAIN_COUNT_DEF,
   localparam int IW = $clog2(GRAIN_COUNT)
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire  smac_pkg::mem_cmd_type cmd,
   input  wire  [IW-1:0]             addr,
   input  wire  [smac_pkg::VAL_W-1:0] wr_data,
   output logic [smac_pkg::VAL_W-1:0] rd_data,
   output logic                      busy
);
   import smac_pkg::*;

   logic [VAL_W-1:0] mem [GRAIN_COUNT];

   logic            busy_ff, busy_in;
   logic [IW-1:0]   idx_ff, idx_in;
   logic [VAL_W-1:0] rd_data_ff;
   logic            we;
   logic [IW-1:0]   wa;
   logic [VAL_W-1:0] wd;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (busy_ff) begin
         idx_in = idx_ff + 1'b1;
         if (idx_ff == IW'(GRAIN_COUNT - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // the sweep owns the write port until every entry is zero
   assign we = busy_ff | cmd.wr_en;
   assign wa = busy_ff ? idx_ff : addr;
   assign wd = busy_ff ? '0 : wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

`default_nettype wire

>>> hw/rtl/smac_ctrl.sv
// sequencer: decodes a request, reads or sweeps the shadow store grain by grain,
// and holds the response register; depends on smac_pkg and the channel interfaces
`timescale 1ns / 1ps
`default_nettype none

module smac_ctrl #(
   parameter int GRAIN_COUNT = smac_pkg::GRAIN_COUNT_DEF,
   localparam int IW = $clog2(GRAIN_COUNT)
) (
   input  wire                        clock,
   input  wire                        reset,
   smac_req_if.sink                   req,
   smac_rsp_if.source                 rsp,
   smac_csr_if.sink                   csr,
   output smac_pkg::mem_cmd_type      mem_cmd,
   output logic [IW-1:0]              mem_addr,
   output logic [smac_pkg::VAL_W-1:0] mem_wr_data,
   input  wire  [smac_pkg::VAL_W-1:0] mem_rd_data,
   input  wire                        mem_busy
);
   import smac_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_EVAL  = 3'd2;
   localparam logic [2:0] ST_SETUP = 3'd3;
   localparam logic [2:0] ST_FILL  = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   localparam logic [31:0] WINDOW_BYTES = 32'(GRAIN_COUNT) << GRAIN_SHIFT;

   logic [2:0]        state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [VAL_W-1:0]  pval_ff, pval_in;
   logic [END_W-1:0]  end_ff, end_in;
   logic [IW-1:0]     grain_ff, grain_in;
   logic [IW-1:0]     last_ff, last_in;
   logic              first_ff, first_in;
   logic              en_ff, en_in;

   logic              res_err_ff, res_err_in;
   logic              res_wr_ff, res_wr_in;
   logic [VAL_W-1:0]  res_sh_ff, res_sh_in;
   logic              res_pois_ff, res_pois_in;
   logic              res_fault_ff, res_fault_in;

   logic              out_valid_ff, out_valid_in;
   logic              out_err_ff, out_err_in;
   logic              out_wr_ff, out_wr_in;
   logic [VAL_W-1:0]  out_sh_ff, out_sh_in;
   logic              out_pois_ff, out_pois_in;
   logic              out_fault_ff, out_fault_in;

   logic [OFFSET_W-1:0] offset;
   logic                in_window;
   logic [IW-1:0]       start_grain;
   logic [VAL_W-1:0]    sh;
   logic                fits;
   logic                over;
   logic [END_W-1:0]    end_m1;

   assign offset      = addr_ff[OFFSET_W-1:0];
   assign in_window   = 32'(addr_ff >> GRAIN_SHIFT) < 32'(GRAIN_COUNT);
   assign start_grain = IW'(addr_ff >> GRAIN_SHIFT);
   assign sh          = in_window ? mem_rd_data : '0;
   assign fits        = (sh < VAL_W'(GRAIN_BYTES)) &&
                        ((END_W'(offset) + END_W'(size_ff)) <= END_W'(sh));
   assign over        = 32'(end_ff) > WINDOW_BYTES;
   assign end_m1      = end_ff - 1'b1;

   assign req.ready = (state_ff == ST_IDLE) && !mem_busy;
   assign csr.ready = 1'b1;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      size_in      = size_ff;
      pval_in      = pval_ff;
      end_in       = end_ff;
      grain_in     = grain_ff;
      last_in      = last_ff;
      first_in     = first_ff;
      en_in        = csr.valid ? csr.checking_enabled : en_ff;
      res_err_in   = res_err_ff;
      res_wr_in    = res_wr_ff;
      res_sh_in    = res_sh_ff;
      res_pois_in  = res_pois_ff;
      res_fault_in = res_fault_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_err_in   = out_err_ff;
      out_wr_in    = out_wr_ff;
      out_sh_in    = out_sh_ff;
      out_pois_in  = out_pois_ff;
      out_fault_in = out_fault_ff;
      mem_cmd      = '0;
      mem_addr     = grain_ff;
      mem_wr_data  = pval_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               op_in        = req.operation;
               addr_in      = req.address;
               size_in      = req.size;
               pval_in      = req.poison_value;
               end_in       = END_W'(req.address) + END_W'(req.size);
               res_err_in   = 1'b0;
               res_wr_in    = 1'b0;
               res_sh_in    = '0;
               res_pois_in  = 1'b0;
               res_fault_in = 1'b0;
               priority if (req.operation == OP_CHECK_READ ||
                            req.operation == OP_CHECK_WRITE ||
                            req.operation == OP_QUERY) begin
                  state_in = ST_READ;
               end else if (req.operation == OP_POISON ||
                            req.operation == OP_UNPOISON) begin
                  state_in = ST_SETUP;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ: begin
            mem_cmd.rd_en = 1'b1;
            mem_addr      = start_grain;
            state_in      = ST_EVAL;
         end
         ST_EVAL: begin
            res_sh_in    = sh;
            res_fault_in = !in_window;
            if (op_ff == OP_QUERY) begin
               res_pois_in = sh != '0;
            end else if (sh != '0 && en_ff && !fits) begin
               res_err_in = 1'b1;
               res_wr_in  = op_ff == OP_CHECK_WRITE;
            end
            state_in = ST_DONE;
         end
         ST_SETUP: begin
            grain_in = start_grain;
            // clipped ranges stop at the last grain of the window
            last_in  = over ? IW'(GRAIN_COUNT - 1) : IW'(end_m1 >> GRAIN_SHIFT);
            first_in = 1'b1;
            if (size_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               res_fault_in = over;
               state_in     = in_window ? ST_FILL : ST_DONE;
            end
         end
         ST_FILL: begin
            mem_cmd.wr_en = 1'b1;
            mem_addr      = grain_ff;
            if (op_ff == OP_UNPOISON) begin
               mem_wr_data = '0;
            end else if (first_ff && offset != '0) begin
               // unaligned start: count of addressable leading bytes
               mem_wr_data = VAL_W'(offset);
            end
            first_in = 1'b0;
            grain_in = grain_ff + 1'b1;
            if (grain_ff == last_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp.ready) begin
               out_valid_in = 1'b1;
               out_err_in   = res_err_ff;
               out_wr_in    = res_wr_ff;
               out_sh_in    = res_sh_ff;
               out_pois_in  = res_pois_ff;
               out_fault_in = res_fault_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         en_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         en_ff        <= en_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      addr_ff      <= addr_in;
      size_ff      <= size_in;
      pval_ff      <= pval_in;
      end_ff       <= end_in;
      grain_ff     <= grain_in;
      last_ff      <= last_in;
      first_ff     <= first_in;
      res_err_ff   <= res_err_in;
      res_wr_ff    <= res_wr_in;
      res_sh_ff    <= res_sh_in;
      res_pois_ff  <= res_pois_in;
      res_fault_ff <= res_fault_in;
      out_err_ff   <= out_err_in;
      out_wr_ff    <= out_wr_in;
      out_sh_ff    <= out_sh_in;
      out_pois_ff  <= out_pois_in;
      out_fault_ff <= out_fault_in;
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.error_flag     = out_err_ff;
   assign rsp.error_is_write = out_wr_ff;
   assign rsp.shadow_value   = out_sh_ff;
   assign rsp.is_poisoned    = out_pois_ff;
   assign rsp.range_fault    = out_fault_ff;

endmodule

`default_nettype wire

>>> hw/rtl/shadow_memory_access_checker.sv
// check and query: an accepted beat passes the READ, EVAL and DONE states, the read in
// READ using the store's registered read port; a new request is taken only in IDLE
// poison and unpoison: SETUP, then one FILL step per grain touched, then DONE
// reset (synchronous) clears checking_enabled and starts a zeroing sweep of all GRAIN_COUNT
// entries; req ready stays low until it ends, csr writes are taken throughout
`timescale 1ns / 1ps
`default_nettype none

module shadow_memory_access_checker #(
   parameter int GRAIN_COUNT = smac_pkg::GRAIN_COUNT_DEF
) (
   input wire          clock,
   input wire          reset,
   smac_req_if.sink    req_chan,
   smac_rsp_if.source  rsp_chan,
   smac_csr_if.sink    csr_chan
);
   import smac_pkg::*;

   localparam int IW = $clog2(GRAIN_COUNT);

   mem_cmd_type      mem_cmd;
   logic [IW-1:0]    mem_addr;
   logic [VAL_W-1:0] mem_wr_data;
   logic [VAL_W-1:0] mem_rd_data;
   logic             mem_busy;

   smac_ctrl #(
      .GRAIN_COUNT (GRAIN_COUNT)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .csr         (csr_chan),
      .mem_cmd     (mem_cmd),
      .mem_addr    (mem_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_data (mem_rd_data),
      .mem_busy    (mem_busy)
   );

   smac_store #(
      .GRAIN_COUNT (GRAIN_COUNT)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mem_cmd),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data),
      .busy    (mem_busy)
   );

endmodule

`default_nettype wire

>>> hw/rtl/smac_checker.sv
// port-level assertions for the shadow memory access checker, bound to the top level
// depends on shadow_memory_access_checker_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "shadow_memory_access_checker_macros.svh"

module smac_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_ready,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire       rsp_error_flag,
   input wire       rsp_error_is_write,
   input wire [7:0] rsp_shadow_value,
   input wire       rsp_is_poisoned
);

   // one request in flight: ready drops right after an accepted beat
   `SMAC_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   // a stalled response beat stays up
   `SMAC_ASSERT_NXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // write kind only comes with an error
   `SMAC_ASSERT_IMP(a_kind_needs_err, clock, reset, rsp_valid && rsp_error_is_write, rsp_error_flag)

   // poisoned query implies a nonzero shadow byte
   `SMAC_ASSERT_IMP(a_pois_nonzero, clock, reset, rsp_valid && rsp_is_poisoned, rsp_shadow_value != 8'd0)

endmodule

bind shadow_memory_access_checker smac_checker u_smac_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_error_flag     (rsp_chan.error_flag),
   .rsp_error_is_write (rsp_chan.error_is_write),
   .rsp_shadow_value   (rsp_chan.shadow_value),
   .rsp_is_poisoned    (rsp_chan.is_poisoned)
);

`default_nettype wire

>>> tb/testbench.sv
// testbench for the shadow memory access checker: directed and random request streams
// against a grain-by-grain shadow copy that predicts every response beat
// depends on smac_pkg, smac_if and shadow_memory_access_checker
`timescale 1ns / 1ps

module testbench;
   import smac_pkg::*;

   localparam int GRAIN_COUNT  = GRAIN_COUNT_DEF;
   localparam int WINDOW_BYTES = GRAIN_COUNT << GRAIN_SHIFT;
   localparam int STALL_LIMIT  = 20000;
   localparam int TAIL_CYCLES  = 8;
   localparam int FULL_RANGE   = 32768;

   localparam logic [OP_W-1:0]  OP_RESERVED_LO  = 3'd5;
   localparam logic [OP_W-1:0]  OP_RESERVED_HI  = 3'd7;
   localparam logic [VAL_W-1:0] CODE_HEAP_LEFT  = 8'hFA;
   localparam logic [VAL_W-1:0] CODE_HEAP_RIGHT = 8'hFB;
   localparam logic [VAL_W-1:0] CODE_FREED      = 8'hFD;
   localparam logic [VAL_W-1:0] CODE_STACK      = 8'hF1;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [ADDR_W-1:0] address;
      logic [SIZE_W-1:0] size;
      logic [VAL_W-1:0]  poison_value;
   } access_type;

   typedef struct packed {
      logic             error_flag;
      logic             error_is_write;
      logic [VAL_W-1:0] shadow_value;
      logic             is_poisoned;
      logic             range_fault;
   } verdict_type;

   bit   clock;
   logic reset = 1'b1;

   smac_req_if req_if ();
   smac_rsp_if rsp_if ();
   smac_csr_if csr_if ();

   shadow_memory_access_checker #(.GRAIN_COUNT(GRAIN_COUNT)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   logic [VAL_W-1:0] shadow_copy [GRAIN_COUNT] = '{default: '0};
   logic             enable_copy = 1'b0;

   access_type  access_backlog [$];
   verdict_type awaited_verdicts [$];

   bit req_beat, csr_beat, req_holding;
   int req_gap, req_calm, rsp_stall, rsp_calm;
   int idle_cycles, mismatches, queued_items, accepted_requests;
   int flagged_checks, clipped_ranges, enable_writes;

   function automatic verdict_type shadow_verdict(input access_type acc);
      verdict_type v;
      int grain, offset, stop;
      v      = '0;
      grain  = acc.address >> GRAIN_SHIFT;
      offset = acc.address & (GRAIN_BYTES - 1);
      case (acc.operation)
         OP_CHECK_READ, OP_CHECK_WRITE, OP_QUERY: begin
            v.shadow_value = shadow_copy[grain];
            if (acc.operation == OP_QUERY) begin
               v.is_poisoned = (v.shadow_value != 0);
            // partial grain: only the leading shadow_value bytes are addressable
            end else if (v.shadow_value != 0 && enable_copy &&
                         !(v.shadow_value < GRAIN_BYTES &&
                           offset + acc.size <= v.shadow_value)) begin
               v.error_flag     = 1'b1;
               v.error_is_write = (acc.operation == OP_CHECK_WRITE);
            end
         end
         OP_POISON, OP_UNPOISON: begin
            if (acc.size != 0) begin
               stop = acc.address + acc.size;
               if (stop > WINDOW_BYTES) begin
                  v.range_fault = 1'b1;
                  stop = WINDOW_BYTES;
               end
               for (int g = grain; g <= (stop - 1) >> GRAIN_SHIFT; g++)
                  shadow_copy[g] = (acc.operation == OP_POISON) ? acc.poison_value : '0;
               // unaligned start keeps the leading bytes of the first grain addressable
               if (acc.operation == OP_POISON && offset != 0)
                  shadow_copy[grain] = VAL_W'(offset);
            end
         end
         default: ;
      endcase
      return v;
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int draw_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      else if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic compare_field(input string field, input logic [VAL_W-1:0] want,
                                input logic [VAL_W-1:0] seen);
      if (seen !== want) begin
         mismatches++;
         $display("%0t: %s expected %0h actual %0h", $time, field, want, seen);
      end
   endtask

   // request driver: new beat presented at the falling edge once the slot is free
   always @(negedge clock) begin
      access_type pick;
      if (!req_if.valid || req_beat) begin
         if (req_gap > 0 || access_backlog.size() == 0) begin
            req_if.valid <= 1'b0;
            req_holding = 1'b0;
            if (req_gap > 0)
               req_gap--;
         end else begin
            pick = access_backlog.pop_front();
            req_holding = 1'b1;
            req_if.valid        <= 1'b1;
            req_if.operation    <= pick.operation;
            req_if.address      <= pick.address;
            req_if.size         <= pick.size;
            req_if.poison_value <= pick.poison_value;
            if (req_calm > 0) begin
               req_calm--;
               req_gap = 0;
            end else begin
               req_gap = draw_gap();
               if ($urandom_range(0, 49) == 0)
                  req_calm = $urandom_range(20, 80);
            end
         end
      end
   end

   // response backpressure
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_if.ready <= 1'b1;
         if (rsp_calm > 0)
            rsp_calm--;
         else if ($urandom_range(0, 2) == 0)
            rsp_stall = draw_gap();
         else if ($urandom_range(0, 99) == 0)
            rsp_calm = $urandom_range(30, 120);
      end
   end

   // monitor: checks response beats, predicts on request beats, tracks the enable bit
   always @(posedge clock) begin
      verdict_type want;
      access_type  acc;
      bit          rsp_beat;
      req_beat = req_if.valid && req_if.ready;
      csr_beat = csr_if.valid && csr_if.ready;
      rsp_beat = rsp_if.valid && rsp_if.ready;
      if (rsp_beat) begin
         if (awaited_verdicts.size() == 0) begin
            mismatches++;
            $display("%0t: response beat with no request outstanding", $time);
         end else begin
            want = awaited_verdicts.pop_front();
            compare_field("error_flag", want.error_flag, rsp_if.error_flag);
            compare_field("error_is_write", want.error_is_write, rsp_if.error_is_write);
            compare_field("shadow_value", want.shadow_value, rsp_if.shadow_value);
            compare_field("is_poisoned", want.is_poisoned, rsp_if.is_poisoned);
            compare_field("range_fault", want.range_fault, rsp_if.range_fault);
         end
         if (rsp_if.error_flag === 1'b1)
            flagged_checks++;
         if (rsp_if.range_fault === 1'b1)
            clipped_ranges++;
      end
      if (req_beat) begin
         acc.operation    = req_if.operation;
         acc.address      = req_if.address;
         acc.size         = req_if.size;
         acc.poison_value = req_if.poison_value;
         awaited_verdicts.push_back(shadow_verdict(acc));
         accepted_requests++;
      end
      if (csr_beat) begin
         enable_copy = csr_if.checking_enabled;
         enable_writes++;
      end
      if (req_beat || csr_beat || rsp_beat)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat on any channel for %0d cycles", $time, STALL_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic queue_access(input logic [OP_W-1:0] op, input int addr, input int len,
                               input int code);
      access_type acc;
      acc.operation    = op;
      acc.address      = ADDR_W'(addr);
      acc.size         = SIZE_W'(len);
      acc.poison_value = VAL_W'(code);
      access_backlog.push_back(acc);
      queued_items++;
   endtask

   task automatic write_enable(input logic value);
      @(negedge clock);
      csr_if.valid            <= 1'b1;
      csr_if.checking_enabled <= value;
      do @(negedge clock); while (!csr_beat);
      csr_if.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (access_backlog.size() != 0 || req_holding || awaited_verdicts.size() != 0);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   // mostly an allocation: open body, poison a right redzone, probe around, maybe free
   task automatic queue_random_burst();
      int base, len, pad, spot, sz, roll, pick;
      logic [OP_W-1:0] op;
      logic [VAL_W-1:0] code;
      if ($urandom_range(0, 9) < 7) begin
         if ($urandom_range(0, 9) == 0)
            base = $urandom_range(WINDOW_BYTES - 256, WINDOW_BYTES - 1);
         else
            base = $urandom_range(0, 2047);
         len  = $urandom_range(1, 64);
         pad  = $urandom_range(1, 32);
         code = ($urandom_range(0, 3) == 0) ? VAL_W'($urandom_range(0, 255)) : CODE_HEAP_RIGHT;
         queue_access(OP_UNPOISON, base, len, 0);
         if (base + len < WINDOW_BYTES)
            queue_access(OP_POISON, base + len, pad, code);
         repeat ($urandom_range(2, 6)) begin
            spot = base + $urandom_range(0, len + pad + 16) - 8;
            if (spot < 0)
               spot = 0;
            if (spot >= WINDOW_BYTES)
               spot = WINDOW_BYTES - 1;
            pick = $urandom_range(0, 4);
            op = (pick == 0) ? OP_QUERY : (pick < 3) ? OP_CHECK_READ : OP_CHECK_WRITE;
            sz = $urandom_range(0, 1) ? (1 << $urandom_range(0, 3)) : $urandom_range(0, 16);
            queue_access(op, spot, sz, $urandom_range(0, 255));
         end
         if ($urandom_range(0, 3) == 0)
            queue_access(OP_POISON, base, len, CODE_FREED);
      end else begin
         op   = OP_W'($urandom_range(OP_CHECK_READ, OP_QUERY));
         roll = $urandom_range(0, 99);
         if (roll < 70)
            sz = $urandom_range(0, 16);
         else if (roll < 96)
            sz = $urandom_range(0, 512);
         else
            sz = $urandom_range(0, FULL_RANGE);
         queue_access(op, $urandom_range(0, WINDOW_BYTES - 1), sz, $urandom_range(0, 255));
      end
   endtask

   task automatic run_random(input int count);
      int goal;
      goal = queued_items + count;
      while (queued_items < goal)
         queue_random_burst();
      wait_drained();
   endtask

   initial begin
      req_if.valid            = 1'b0;
      req_if.operation        = OP_QUERY;
      req_if.address          = '0;
      req_if.size             = '0;
      req_if.poison_value     = '0;
      rsp_if.ready            = 1'b0;
      csr_if.valid            = 1'b0;
      csr_if.checking_enabled = 1'b0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      write_enable(1'b1);

      queue_access(OP_QUERY, 0, 0, 0);
      queue_access(OP_CHECK_READ, 0, 8, 0);
      queue_access(OP_POISON, 'h40, 16, CODE_HEAP_LEFT);
      queue_access(OP_CHECK_READ, 'h40, 1, 0);
      queue_access(OP_CHECK_WRITE, 'h48, 4, 0);
      queue_access(OP_QUERY, 'h48, 0, 0);
      // unaligned poison leaves three addressable bytes in its first grain
      queue_access(OP_POISON, 'h83, 20, CODE_STACK);
      queue_access(OP_CHECK_READ, 'h80, 3, 0);
      queue_access(OP_CHECK_WRITE, 'h81, 3, 0);
      queue_access(OP_CHECK_READ, 'h82, 0, 0);
      queue_access(OP_UNPOISON, 'h40, 16, 0);
      queue_access(OP_CHECK_READ, 'h40, 8, 0);
      queue_access(OP_POISON, 'h100, 0, 'hFF);
      queue_access(OP_QUERY, 'h100, 0, 0);
      // ranges running off the top of the window
      queue_access(OP_POISON, 'h7FF8, 16, 'hFF);
      queue_access(OP_QUERY, 'h7FFF, 0, 0);
      queue_access(OP_UNPOISON, 'h7FFF, 1, 0);
      queue_access(OP_POISON, 'h7FFF, FULL_RANGE, 0);
      queue_access(OP_CHECK_WRITE, 'h7FF8, FULL_RANGE, 0);
      queue_access(OP_POISON, 0, FULL_RANGE, 'hAB);
      queue_access(OP_CHECK_READ, 'h1234, 1, 0);
      queue_access(OP_UNPOISON, 0, FULL_RANGE, 0);
      // a small value written as a code acts as a partial grain
      queue_access(OP_POISON, 'h200, 8, 5);
      queue_access(OP_CHECK_READ, 'h204, 1, 0);
      queue_access(OP_CHECK_WRITE, 'h205, 1, 0);
      queue_access(OP_RESERVED_LO, 'h200, 8, 'h55);
      queue_access(OP_RESERVED_HI, 'h7FFF, FULL_RANGE, 'hFF);
      wait_drained();

      run_random(160);
      write_enable(1'b0);
      run_random(80);
      write_enable(1'b1);
      run_random(160);

      $display("covered %0d requests over %0d enable writes, %0d checks flagged",
               accepted_requests, enable_writes, flagged_checks);
      $display("%0d responses reported a range clipped at the window top", clipped_ranges);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
